>>> src/rcexpo_pkg.sv
// ----------------------------------------------------------------------------
// rcexpo_pkg
// Shared constants, register map, template codes and helpers for the expo
// curve point generator.
// ----------------------------------------------------------------------------
package rcexpo_pkg;

  // Default number of fractional bits in the x position
  localparam int XFB_DEFAULT = 8;

  // Configuration port geometry
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;
  localparam int REG_IW = 3;

  // Register indexes (byte address = 4 * index)
  localparam logic [REG_IW-1:0] REG_TEMPLATE = 3'd0;
  localparam logic [REG_IW-1:0] REG_COEFF    = 3'd1;
  localparam logic [REG_IW-1:0] REG_Y_LOW    = 3'd2;
  localparam logic [REG_IW-1:0] REG_Y_MIDDLE = 3'd3;
  localparam logic [REG_IW-1:0] REG_Y_HIGH   = 3'd4;
  localparam logic [REG_IW-1:0] REG_SIDE     = 3'd5;

  // Curve templates
  localparam logic [1:0] TPL_LINEAR = 2'd0;
  localparam logic [1:0] TPL_SINGLE = 2'd1;
  localparam logic [1:0] TPL_ODD    = 2'd2;
  localparam logic [1:0] TPL_EVEN   = 2'd3;

  // Side selection
  localparam logic [1:0] SIDE_ALL = 2'd0;
  localparam logic [1:0] SIDE_POS = 2'd1;
  localparam logic [1:0] SIDE_NEG = 2'd2;

  // Register reset values
  localparam logic [7:0] Y_LOW_RST  = 8'h9C;
  localparam logic [7:0] Y_HIGH_RST = 8'h64;

  // Pipeline depth
  localparam int NSTG = 10;

  // Expo kernel: one unit of the kernel is 390625 (5^8), linear term 80000
  localparam int          EXPO_UNIT_W = 19;
  localparam logic [18:0] EXPO_UNIT   = 19'd390625;
  localparam logic [16:0] KERN_LIN    = 17'd80000;

  // Final divide by 390625: quotient is floor(t * EXPO_RECIP / 2^45), t < 2^26
  localparam int          QT_W        = 26;
  localparam int          EXPO_RCP_W  = 27;
  localparam logic [26:0] EXPO_RECIP  = 27'd90071993;
  localparam int          EXPO_RCP_SH = 45;

  // Linear divide by 25: floor(t * 5243 / 2^17), t < 2^12
  localparam int          LT_W       = 12;
  localparam int          LIN_RCP_W  = 13;
  localparam logic [12:0] LIN_RECIP  = 13'd5243;
  localparam int          LIN_RCP_SH = 17;

  // Per-word side flags carried down the pipeline
  typedef struct packed {
    logic xneg;
    logic apply;
  } rcx_flags_t;

  // Saturate a signed register value to +-100
  function automatic logic signed [7:0] clamp100(input logic signed [7:0] v);
    if (v > 8'sd100) begin
      return 8'sd100;
    end else if (v < -8'sd100) begin
      return -8'sd100;
    end else begin
      return v;
    end
  endfunction

endpackage

>>> src/rc_expo_curve_generator_top.sv
// ----------------------------------------------------------------------------
// rc_expo_curve_generator_top: expo curve point generator
// Pipeline: ten register stages; a word accepted into stage 1 moves through
//   the stage registers and is offered on the out_ channel from stage 10.
// Throughput: one word per cycle while out_ready holds; each stage holds one
//   word and collapses bubbles, so a stalled output only stops occupied stages.
// Reset: synchronous, active low; clears stage valid bits and loads the
//   register defaults (linear, coeff 0, y_low -100, y_middle 0, y_high 100).
// ----------------------------------------------------------------------------
module rc_expo_curve_generator_top #(
  parameter int X_FRAC_BITS = rcexpo_pkg::XFB_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rcexpo_pkg::CFG_AW-1:0]   paddr,
  input  logic [rcexpo_pkg::CFG_DW-1:0]   pwdata,
  output logic [rcexpo_pkg::CFG_DW-1:0]   prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [15:0]              in_x_pos,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [7:0]               out_y_value,
  output logic                            out_apply_point
);
  import rcexpo_pkg::*;

  // Datapath widths; the kernel runs with DD fractional bits for every template
  localparam int DD  = X_FRAC_BITS + 1;
  localparam int XW  = (X_FRAC_BITS + 9 > 17) ? X_FRAC_BITS + 9 : 17;
  localparam int PW  = X_FRAC_BITS + 8;
  localparam int P2W = 2 * PW;
  localparam int P3W = 3 * PW;
  localparam int PKW = PW + 7;
  localparam int PBW = X_FRAC_BITS + 31;
  localparam int MW  = 3 * DD + 30;
  localparam int AAW = MW - 3;
  localparam int NW  = MW + 10;
  localparam int AW  = NW + 1;
  localparam int SQ  = 3 * DD + 11;
  localparam int LNW = X_FRAC_BITS + 18;
  localparam int LQW = LT_W + LIN_RCP_W;
  localparam int QPW = QT_W + EXPO_RCP_W;

  localparam logic signed [XW-1:0] LIMX = XW'(100 << X_FRAC_BITS);
  localparam logic [MW-1:0] MONE = {{(MW-EXPO_UNIT_W){1'b0}}, EXPO_UNIT} << (3 * DD);
  localparam logic [AW-1:0] QONE = {{(AW-EXPO_UNIT_W){1'b0}}, EXPO_UNIT} << SQ;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [1:0]        tpl_r;
  logic signed [7:0] coeff_r;
  logic signed [7:0] ylow_r;
  logic signed [7:0] ymid_r;
  logic signed [7:0] yhigh_r;
  logic [1:0]        side_r;
  logic              cfg_wr;
  logic [REG_IW-1:0] cfg_idx;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[CFG_AW-1:2];

  // Write a register on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpl_r   <= TPL_LINEAR;
      coeff_r <= '0;
      ylow_r  <= Y_LOW_RST;
      ymid_r  <= '0;
      yhigh_r <= Y_HIGH_RST;
      side_r  <= SIDE_ALL;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_TEMPLATE: tpl_r   <= pwdata[1:0];
        REG_COEFF:    coeff_r <= pwdata[7:0];
        REG_Y_LOW:    ylow_r  <= pwdata[7:0];
        REG_Y_MIDDLE: ymid_r  <= pwdata[7:0];
        REG_Y_HIGH:   yhigh_r <= pwdata[7:0];
        REG_SIDE:     side_r  <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (cfg_idx)
      REG_TEMPLATE: prdata = {{(CFG_DW-2){1'b0}}, tpl_r};
      REG_COEFF:    prdata = {{(CFG_DW-8){1'b0}}, coeff_r};
      REG_Y_LOW:    prdata = {{(CFG_DW-8){1'b0}}, ylow_r};
      REG_Y_MIDDLE: prdata = {{(CFG_DW-8){1'b0}}, ymid_r};
      REG_Y_HIGH:   prdata = {{(CFG_DW-8){1'b0}}, yhigh_r};
      REG_SIDE:     prdata = {{(CFG_DW-2){1'b0}}, side_r};
      default:      prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Constants from registers, kept static by user while words fly (unchecked)
  // --------------------------------------------------------------------------
  logic signed [7:0] coeff_c, ylo_c, ymd_c, yhi_c;
  logic [7:0]        coeff_abs;
  logic              mirror;
  logic [6:0]        cm, kc;
  logic [8:0]        ylo9, ymd9, yhi9;
  logic [8:0]        ym, yb, sm, so, dy;
  logic [15:0]       yl200;
  logic [LNW-1:0]    lbase;

  always_comb begin
    coeff_c   = clamp100(coeff_r);
    ylo_c     = clamp100(ylow_r);
    ymd_c     = clamp100(ymid_r);
    yhi_c     = clamp100(yhigh_r);
    mirror    = coeff_c[7];
    coeff_abs = mirror ? 8'd0 - coeff_c : coeff_c;
    cm        = coeff_abs[6:0];
    kc        = 7'd100 - cm;
    ylo9      = {ylo_c[7], ylo_c};
    ymd9      = {ymd_c[7], ymd_c};
    yhi9      = {yhi_c[7], yhi_c};
    dy        = yhi9 - ylo9;
    // Pick kernel scale and offset for the template
    case (tpl_r)
      TPL_SINGLE: begin
        ym = yhi9 - ylo9;
        yb = ylo9;
      end
      TPL_ODD: begin
        ym = yhi9;
        yb = '0;
      end
      default: begin
        ym = yhi9 - ymd9;
        yb = ymd9;
      end
    endcase
    // Mirror flips the kernel: offset moves to the far end
    sm    = mirror ? 9'd0 - ym : ym;
    so    = mirror ? ym + yb : yb;
    // Linear offset ylo * 200 * 2^X
    yl200 = {{8{ylo_c[7]}}, ylo_c} * 16'd200;
    lbase = {{(LNW-16){yl200[15]}}, yl200} << X_FRAC_BITS;
  end

  // --------------------------------------------------------------------------
  // Stage control: each stage advances when empty or when the next one moves
  // --------------------------------------------------------------------------
  logic [NSTG-1:0] valid_r, valid_nxt, adv;
  rcx_flags_t      fl_r [NSTG];
  rcx_flags_t      fl_in;

  always_comb begin
    adv[NSTG-1] = !valid_r[NSTG-1] || out_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      adv[i] = !valid_r[i] || adv[i+1];
    end
    for (int i = 0; i < NSTG; i++) begin
      if (adv[i]) begin
        valid_nxt[i] = (i == 0) ? in_valid : valid_r[i-1];
      end else begin
        valid_nxt[i] = valid_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = valid_r[NSTG-1];

  // --------------------------------------------------------------------------
  // Stage 1: saturate x, form kernel position p and side flags
  // --------------------------------------------------------------------------
  logic signed [XW-1:0] xs, xc, xl_w, xm_w, ax, sq_w;
  logic [PW-1:0]        psym, s1_p_nxt, s1_p_r, s1_xl_nxt, s1_xl_r;

  always_comb begin
    xs = {{(XW-16){in_x_pos[15]}}, in_x_pos};
    if (xs > LIMX) begin
      xc = LIMX;
    end else if (xs < -LIMX) begin
      xc = -LIMX;
    end else begin
      xc = xs;
    end
    xl_w      = xc + LIMX;
    xm_w      = LIMX - xc;
    ax        = xc[XW-1] ? -xc : xc;
    sq_w      = mirror ? LIMX - ax : ax;
    // Symmetric templates use |x| at half the scale, doubled to match
    psym      = {sq_w[PW-2:0], 1'b0};
    s1_xl_nxt = xl_w[PW-1:0];
    case (tpl_r)
      TPL_SINGLE: s1_p_nxt = mirror ? xm_w[PW-1:0] : xl_w[PW-1:0];
      TPL_ODD:    s1_p_nxt = psym;
      TPL_EVEN:   s1_p_nxt = psym;
      default:    s1_p_nxt = xl_w[PW-1:0];
    endcase
    fl_in.xneg = in_x_pos[15];
    case (side_r)
      SIDE_ALL: fl_in.apply = 1'b1;
      SIDE_POS: fl_in.apply = !in_x_pos[15];
      SIDE_NEG: fl_in.apply = in_x_pos[15];
      default:  fl_in.apply = 1'b0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Stages 2..10: kernel products, blend, rounding, signs and constant divides
  // --------------------------------------------------------------------------
  logic [P2W-1:0] s2_p2_nxt, s2_p2_r;
  logic [PW-1:0]  s2_p_r;
  logic [PKW-1:0] s2_pk_nxt, s2_pk_r;
  logic [LNW-1:0] s2_lprod_nxt, s2_lprod_r;

  logic [P3W-1:0] s3_p3_nxt, s3_p3_r;
  logic [PBW-1:0] s3_pb_nxt, s3_pb_r;
  logic [LNW-1:0] s3_lnum_nxt, s3_lnum_r;

  logic [AAW-1:0]  s4_a_nxt, s4_a_r;
  logic [PBW-1:0]  s4_pb_r;
  logic [LNW-1:0]  lmag;
  logic            s4_lneg_nxt, s4_lneg_r;
  logic [LT_W-1:0] s4_lt_nxt, s4_lt_r;

  logic [MW-1:0]  s5_m_nxt, s5_m_r;
  logic [LQW-1:0] s5_lq_nxt, s5_lq_r;
  logic           s5_lneg_r;

  logic [NW-1:0] s6_n1_nxt, s6_n1_r;
  logic [27:0]   s6_n2_nxt, s6_n2_r;
  logic [7:0]    lyu;
  logic [7:0]    s6_ly_nxt, s6_ly_r;

  logic [NW-1:0] s7_n_nxt, s7_n_r;
  logic [7:0]    s7_ly_r;

  logic [AW-1:0]   twon, aval;
  logic            s8_neg_nxt, s8_neg_r;
  logic [QT_W-1:0] s8_t_nxt, s8_t_r;
  logic [7:0]      s8_ly_r;

  logic [QPW-1:0] qp;
  logic [7:0]     s9_qy_nxt, s9_qy_r;
  logic           s9_neg_r;
  logic [7:0]     s9_ly_r;

  logic       sgn;
  logic [7:0] ye;
  logic [7:0] out_y_nxt, out_y_r;

  always_comb begin
    // Stage 2: p^2, p*(100-c), linear slope term
    s2_p2_nxt    = P2W'(s1_p_r) * P2W'(s1_p_r);
    s2_pk_nxt    = PKW'(s1_p_r) * PKW'(kc);
    s2_lprod_nxt = {{(LNW-PW){1'b0}}, s1_xl_r} * {{(LNW-9){dy[8]}}, dy};

    // Stage 3: p^3, linear kernel term, linear numerator
    s3_p3_nxt   = P3W'(s2_p2_r) * P3W'(s2_p_r);
    s3_pb_nxt   = PBW'(s2_pk_r) * PBW'(KERN_LIN);
    s3_lnum_nxt = lbase + s2_lprod_r;

    // Stage 4: c*p^3; linear magnitude scaled down by 8 * 2^X
    s4_a_nxt    = AAW'(s3_p3_r) * AAW'(cm);
    s4_lneg_nxt = s3_lnum_r[LNW-1];
    lmag        = s4_lneg_nxt ? (~s3_lnum_r) + LNW'(1) : s3_lnum_r;
    s4_lt_nxt   = lmag[X_FRAC_BITS+3 +: LT_W];

    // Stage 5: sum the kernel; divide linear magnitude by 25
    s5_m_nxt  = {s4_a_r, 3'b000} + ({{(MW-PBW){1'b0}}, s4_pb_r} << (2 * DD)) + MONE;
    s5_lq_nxt = LQW'(s4_lt_r) * LQW'(LIN_RECIP);

    // Stage 6: scale kernel by slope, offset by 390625 units; finish linear
    s6_n1_nxt = {{(NW-MW){1'b0}}, s5_m_r} * {{(NW-9){sm[8]}}, sm};
    s6_n2_nxt = {{19{so[8]}}, so} * {9'd0, EXPO_UNIT};
    lyu       = s5_lq_r[LIN_RCP_SH +: 8];
    s6_ly_nxt = s5_lneg_r ? 8'd0 - lyu : lyu;

    // Stage 7: blended numerator
    s7_n_nxt = s6_n1_r + ({{(NW-28){s6_n2_r[27]}}, s6_n2_r} << SQ);

    // Stage 8: 2|N| + q, then drop the power-of-two part of 2q
    s8_neg_nxt = s7_n_r[NW-1];
    twon       = {s7_n_r, 1'b0};
    aval       = s8_neg_nxt ? QONE - twon : QONE + twon;
    s8_t_nxt   = aval[SQ+1 +: QT_W];

    // Stage 9: divide by 390625
    qp        = QPW'(s8_t_r) * QPW'(EXPO_RECIP);
    s9_qy_nxt = qp[EXPO_RCP_SH +: 8];

    // Stage 10: restore sign, flip for odd symmetry, pick template
    sgn = s9_neg_r ^ ((tpl_r == TPL_ODD) && fl_r[NSTG-2].xneg);
    ye  = sgn ? 8'd0 - s9_qy_r : s9_qy_r;
    out_y_nxt = (tpl_r == TPL_LINEAR) ? s9_ly_r : ye;
  end

  // Advance the payload registers stage by stage
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_p_r  <= s1_p_nxt;
      s1_xl_r <= s1_xl_nxt;
      fl_r[0] <= fl_in;
    end
    for (int i = 1; i < NSTG; i++) begin
      if (adv[i]) begin
        fl_r[i] <= fl_r[i-1];
      end
    end
    if (adv[1]) begin
      s2_p2_r    <= s2_p2_nxt;
      s2_p_r     <= s1_p_r;
      s2_pk_r    <= s2_pk_nxt;
      s2_lprod_r <= s2_lprod_nxt;
    end
    if (adv[2]) begin
      s3_p3_r   <= s3_p3_nxt;
      s3_pb_r   <= s3_pb_nxt;
      s3_lnum_r <= s3_lnum_nxt;
    end
    if (adv[3]) begin
      s4_a_r    <= s4_a_nxt;
      s4_pb_r   <= s3_pb_r;
      s4_lneg_r <= s4_lneg_nxt;
      s4_lt_r   <= s4_lt_nxt;
    end
    if (adv[4]) begin
      s5_m_r    <= s5_m_nxt;
      s5_lq_r   <= s5_lq_nxt;
      s5_lneg_r <= s4_lneg_r;
    end
    if (adv[5]) begin
      s6_n1_r <= s6_n1_nxt;
      s6_n2_r <= s6_n2_nxt;
      s6_ly_r <= s6_ly_nxt;
    end
    if (adv[6]) begin
      s7_n_r  <= s7_n_nxt;
      s7_ly_r <= s6_ly_r;
    end
    if (adv[7]) begin
      s8_neg_r <= s8_neg_nxt;
      s8_t_r   <= s8_t_nxt;
      s8_ly_r  <= s7_ly_r;
    end
    if (adv[8]) begin
      s9_qy_r  <= s9_qy_nxt;
      s9_neg_r <= s8_neg_r;
      s9_ly_r  <= s8_ly_r;
    end
    if (adv[9]) begin
      out_y_r <= out_y_nxt;
    end
  end

  assign out_y_value     = out_y_r;
  assign out_apply_point = fl_r[NSTG-1].apply;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
`ifndef NO_ASSERTIONS
  a_y_range: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid |-> (out_y_value <= 8'sd101 && out_y_value >= -8'sd101))
    else $error("curve output out of range");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
      (&valid_r && !out_ready) |-> !in_ready)
    else $error("word taken while every stage is held");

  a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid && out_ready && !valid_r[NSTG-2]) |=> !out_valid)
    else $error("output word repeated after it was taken");
`endif

endmodule

>>> tb/tb_rc_expo_curve_generator_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rc_expo_curve_generator_top
// Streams curve points through the expo curve generator under a series of
// register settings and checks every result word against a local predictor
// that evaluates each template as exact rational arithmetic.
// ----------------------------------------------------------------------------
module tb_rc_expo_curve_generator_top;
  import rcexpo_pkg::*;

  localparam int XFB         = XFB_DEFAULT;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PIPE_SLACK  = 20;

  typedef enum {RX_FREE, RX_RANDOM, RX_PATTERN} rx_mode_e;

  typedef struct packed {
    logic signed [7:0] y_value;
    logic              apply_point;
  } curve_point_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [CFG_AW-1:0]       paddr = '0;
  logic [CFG_DW-1:0]       pwdata = '0;
  logic [CFG_DW-1:0]       prdata;
  logic                    pready;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [15:0]      in_x_pos = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [7:0]       out_y_value;
  logic                    out_apply_point;

  // Register shadow, as the block holds it after reset
  logic [1:0]              cur_template = TPL_LINEAR;
  logic signed [7:0]       cur_coeff = '0;
  logic signed [7:0]       cur_ylow = Y_LOW_RST;
  logic signed [7:0]       cur_ymid = '0;
  logic signed [7:0]       cur_yhigh = Y_HIGH_RST;
  logic [1:0]              cur_side = SIDE_ALL;

  logic signed [15:0]      pending_x[$];
  curve_point_t            expected_points[$];
  bit                      in_fire;
  int                      fail_count = 0;
  int                      cycle_count = 0;

  // Sender and receiver pacing
  bit                      tx_bursty = 1'b0;
  int                      burst_left = 1;
  int                      gap_left = 0;
  rx_mode_e                rx_mode = RX_FREE;
  int                      hold_req = 0;
  int                      hold_left = 0;
  logic [15:0]             rx_pattern = 16'hFFFF;
  int                      rx_bit = 0;

  rc_expo_curve_generator_top #(
    .X_FRAC_BITS(XFB)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_x_pos(in_x_pos),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_y_value(out_y_value),
    .out_apply_point(out_apply_point)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int sat100(input logic signed [7:0] v);
    int iv;
    iv = v;
    return (iv > 100) ? 100 : ((iv < -100) ? -100 : iv);
  endfunction

  // Expo kernel scaled by ym and offset by yb, rounded half away from zero.
  // p is the kernel position with d fractional bits, c the coefficient.
  function automatic int expo_y(input longint p, input int d, input longint c,
                                input bit mirror, input int ym, input int yb);
    logic signed [127:0] pw, cw, den2, den3, m, q, v, a;
    int                  sm, so;
    longint              r;
    pw   = p;
    cw   = c;
    den2 = 128'sd1 << (2 * d);
    den3 = 128'sd1 << (3 * d);
    m    = 8 * cw * pw * pw * pw + 80000 * pw * (100 - cw) * den2 + 390625 * den3;
    q    = 390625 * den3 * 2048;
    sm   = mirror ? -ym : ym;
    so   = mirror ? ym + yb : yb;
    v    = sm * m + so * q;
    a    = (v < 0) ? 2 * (-v) + q : 2 * v + q;
    a    = a >> (12 + 3 * d);
    r    = a / 390625;
    return (v < 0) ? -int'(r) : int'(r);
  endfunction

  // Expected result word for one point under the current register shadow
  function automatic curve_point_t predict_point(input logic signed [15:0] xin);
    longint       sc, lim, xr, x, ax, cm, num;
    int           c, ylo, ymd, yhi, y;
    bit           mirror;
    curve_point_t res;
    sc     = longint'(1) << XFB;
    lim    = 100 * sc;
    xr     = xin;
    x      = (xr > lim) ? lim : ((xr < -lim) ? -lim : xr);
    c      = sat100(cur_coeff);
    ylo    = sat100(cur_ylow);
    ymd    = sat100(cur_ymid);
    yhi    = sat100(cur_yhigh);
    mirror = (c < 0);
    cm     = mirror ? -c : c;
    ax     = (x < 0) ? -x : x;
    case (cur_template)
      TPL_LINEAR: begin
        num = longint'(ylo) * 200 * sc + longint'(yhi - ylo) * (x + lim);
        y   = int'(num / (200 * sc));
      end
      TPL_SINGLE: begin
        y = expo_y(mirror ? lim - x : x + lim, XFB + 1, cm, mirror, yhi - ylo, ylo);
      end
      TPL_ODD: begin
        y = expo_y(mirror ? lim - ax : ax, XFB, cm, mirror, yhi, 0);
        if (x < 0) begin
          y = -y;
        end
      end
      default: begin
        y = expo_y(mirror ? lim - ax : ax, XFB, cm, mirror, yhi - ymd, ymd);
      end
    endcase
    res.y_value = y[7:0];
    case (cur_side)
      SIDE_ALL: res.apply_point = 1'b1;
      SIDE_POS: res.apply_point = (xr >= 0);
      SIDE_NEG: res.apply_point = (xr < 0);
      default:  res.apply_point = 1'b0;
    endcase
    return res;
  endfunction

  // Record each accepted point with its expected result
  always @(posedge clk) begin
    in_fire = rst_n && in_valid && in_ready;
    if (in_fire) begin
      expected_points.push_back(predict_point(in_x_pos));
    end
  end

  // Feed points, in bursts when tx_bursty is set; hold the word until it is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (tx_bursty && gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_x.size() != 0) begin
        in_valid <= 1'b1;
        in_x_pos <= pending_x.pop_front();
        if (tx_bursty) begin
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left   = $urandom_range(1, 6);
          end
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side backpressure: long hold-off first, then the current mode
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_FREE:   out_ready <= 1'b1;
        RX_RANDOM: out_ready <= ($urandom_range(0, 2) != 0);
        default: begin
          out_ready <= rx_pattern[rx_bit];
          rx_bit++;
          if (rx_bit == 16) begin
            rx_bit     = 0;
            rx_pattern = $urandom;
          end
        end
      endcase
    end
  end

  // Compare each result word with the oldest expectation
  always @(posedge clk) begin
    curve_point_t exp_pt;
    if (rst_n && out_valid && out_ready) begin
      if (expected_points.size() == 0) begin
        $error("unexpected result word: y_value %0d apply_point %0d",
               out_y_value, out_apply_point);
        fail_count++;
      end else begin
        exp_pt = expected_points.pop_front();
        if (out_y_value !== exp_pt.y_value) begin
          $error("y_value mismatch: expected %0d, actual %0d",
                 exp_pt.y_value, out_y_value);
          fail_count++;
        end
        if (out_apply_point !== exp_pt.apply_point) begin
          $error("apply_point mismatch: expected %0d, actual %0d",
                 exp_pt.apply_point, out_apply_point);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Register write: setup cycle, then access cycle; shadow follows the write
  task automatic cfg_write(input logic [REG_IW-1:0] idx, input logic [7:0] val);
    logic [CFG_DW-1:0] word;
    word       = $urandom;
    word[7:0]  = val;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_TEMPLATE: cur_template = word[1:0];
      REG_COEFF:    cur_coeff    = word[7:0];
      REG_Y_LOW:    cur_ylow     = word[7:0];
      REG_Y_MIDDLE: cur_ymid     = word[7:0];
      REG_Y_HIGH:   cur_yhigh    = word[7:0];
      REG_SIDE:     cur_side     = word[1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic cfg_write_all(input logic [1:0] tpl, input logic [7:0] coeff,
                               input logic [7:0] ylo, input logic [7:0] ymid,
                               input logic [7:0] yhi, input logic [1:0] side);
    cfg_write(REG_TEMPLATE, {6'd0, tpl});
    cfg_write(REG_COEFF, coeff);
    cfg_write(REG_Y_LOW, ylo);
    cfg_write(REG_Y_MIDDLE, ymid);
    cfg_write(REG_Y_HIGH, yhi);
    cfg_write(REG_SIDE, {6'd0, side});
  endtask

  // Wait until every point is taken and every result is back, then settle
  task automatic wait_for_idle(input int max_wait);
    int waited;
    waited = 0;
    while ((pending_x.size() != 0 || in_valid || expected_points.size() != 0)
           && waited < max_wait) begin
      @(posedge clk);
      waited++;
    end
    repeat (PIPE_SLACK) @(posedge clk);
  endtask

  // Register value: mostly in range, with the saturation edges mixed in
  function automatic logic [7:0] pick_reg8();
    case ($urandom_range(0, 9))
      0: return 8'h80;
      1: return 8'h9C;
      2: return 8'h64;
      3: return 8'h7F;
      4: return 8'($urandom_range(0, 255));
      default: return 8'($signed($urandom_range(0, 200)) - 100);
    endcase
  endfunction

  // Point position: mostly in range, some edges, some full 16-bit noise
  function automatic logic signed [15:0] pick_x();
    case ($urandom_range(0, 9))
      0: return 16'($urandom_range(0, 65535));
      1: begin
        case ($urandom_range(0, 6))
          0: return -16'sd25600;
          1: return 16'sd25600;
          2: return -16'sd25599;
          3: return 16'sd25599;
          4: return -16'sd1;
          5: return 16'sd1;
          default: return 16'sd0;
        endcase
      end
      default: return 16'($signed($urandom_range(0, 51200)) - 25600);
    endcase
  endfunction

  initial begin
    logic signed [15:0] reset_pts[7] = '{-16'sd32768, -16'sd25600, -16'sd1, 16'sd0,
                                         16'sd1, 16'sd25600, 16'sd32767};
    logic signed [15:0] single_pts[6] = '{-16'sd25600, -16'sd12800, -16'sd1, 16'sd0,
                                          16'sd12800, 16'sd25600};
    logic signed [15:0] odd_pts[6] = '{-16'sd25600, -16'sd128, -16'sd1, 16'sd0,
                                       16'sd1, 16'sd25600};
    logic signed [15:0] even_pts[6] = '{-16'sd32768, -16'sd25600, 16'sd0, 16'sd256,
                                        16'sd25600, 16'sd32767};

    // Hold reset, then release it once
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Reset register values, linear template, saturated x at both ends
    foreach (reset_pts[i]) pending_x.push_back(reset_pts[i]);
    wait_for_idle(5000);

    // Single expo at full coefficient, positive side only
    cfg_write_all(TPL_SINGLE, 8'd100, 8'h9C, 8'h00, 8'h64, SIDE_POS);
    foreach (single_pts[i]) pending_x.push_back(single_pts[i]);
    wait_for_idle(5000);

    // Odd symmetric, mirrored kernel, negative side only
    cfg_write_all(TPL_ODD, 8'h9C, 8'h00, 8'h00, 8'h64, SIDE_NEG);
    foreach (odd_pts[i]) pending_x.push_back(odd_pts[i]);
    wait_for_idle(5000);

    // Even symmetric, registers beyond range, unused side code
    cfg_write_all(TPL_EVEN, 8'h7F, 8'h80, 8'h80, 8'h7F, 2'd3);
    foreach (even_pts[i]) pending_x.push_back(even_pts[i]);
    wait_for_idle(5000);

    // Random settings, points and pacing
    for (int ph = 0; ph < 10; ph++) begin
      cfg_write_all(2'(ph % 4), pick_reg8(), pick_reg8(), pick_reg8(), pick_reg8(),
                    2'($urandom_range(0, 3)));
      if (ph == 0 || ph == 2) begin
        tx_bursty = 1'b0;
        rx_mode   = RX_FREE;
      end else begin
        tx_bursty = $urandom_range(0, 1);
        rx_mode   = rx_mode_e'($urandom_range(0, 2));
      end
      // Starve the result side long enough that the pipe backs up
      if (ph == 2) begin
        hold_req = 400;
      end
      for (int n = 0; n < 105; n++) begin
        pending_x.push_back(pick_x());
      end
      wait_for_idle(50000);
    end

    if (expected_points.size() != 0) begin
      $error("%0d result words never arrived", expected_points.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
